FILE: rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the alphabet lookup for the Base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	// Character classes produced by the front end
	localparam logic [1:0] CLS_SEXTET = 2'd0;
	localparam logic [1:0] CLS_PAD    = 2'd1;
	localparam logic [1:0] CLS_BAD    = 2'd2;

	// Result kinds on the output stream
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_PAD  = 2'd2;
	localparam logic [1:0] KIND_BAD  = 2'd3;

	// Classified character as it travels through the queue
	typedef struct packed {
		logic [1:0] cls;
		logic [5:0] sextet;
		logic       last;
	} b64d_entry_t;

	// Alphabet map: sextet value, valid flag in the top bit
	function automatic logic [6:0] sextet_of(input logic [7:0] ch);
		logic [6:0] res;
		res = 7'd0;
		case (ch) inside
			[8'h41:8'h5A]: res = {1'b1, 6'(ch - 8'h41)};
			[8'h61:8'h7A]: res = {1'b1, 6'(ch - 8'h61 + 8'd26)};
			[8'h30:8'h39]: res = {1'b1, 6'(ch - 8'h30 + 8'd52)};
			8'h2B:         res = {1'b1, 6'd62};
			8'h2F:         res = {1'b1, 6'd63};
			default:       res = 7'd0;
		endcase
		return res;
	endfunction

endpackage

FILE: rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Classifies an incoming character: alphabet sextet, padding or invalid.
// ----------------------------------------------------------------------------
module b64d_front
	import b64d_pkg::*;
(
	input  logic [7:0]  code_char,
	input  logic        message_last,
	output b64d_entry_t entry
);

	logic [6:0] lookup;

	// Alphabet lookup and class decode
	always_comb begin
		lookup       = sextet_of(code_char);
		entry.last   = message_last;
		entry.sextet = lookup[5:0];
		if (code_char == 8'h3D) begin
			entry.cls = CLS_PAD;
		end else if (lookup[6]) begin
			entry.cls = CLS_SEXTET;
		end else begin
			entry.cls = CLS_BAD;
		end
	end

endmodule

FILE: rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Small register FIFO between the classifier and the decode back end.
// ----------------------------------------------------------------------------
module b64d_queue
	import b64d_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  b64d_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output b64d_entry_t head,
	output logic        nonempty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64d_entry_t     mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	// Storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Group tracking, byte assembly and the registered result stage.
// ----------------------------------------------------------------------------
module b64d_back
	import b64d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_nonempty,
	input  b64d_entry_t q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte,
	output logic [1:0]  kind,
	output logic        end_of_message
);

	logic [1:0] pos_q;
	logic [5:0] pend_q;
	logic       stopped_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic [1:0] kind_q;
	logic       eom_q;

	logic [1:0] pos_d;
	logic [5:0] pend_d;
	logic       stopped_d;
	logic       has_res;
	logic [7:0] res_byte;
	logic [1:0] res_kind;

	// Take an entry whenever the result register is free or draining
	assign q_pop = q_nonempty && (!out_valid_q || out_ready);

	// Decode step for the head entry
	always_comb begin
		pos_d     = pos_q;
		pend_d    = pend_q;
		stopped_d = stopped_q;
		has_res   = 1'b0;
		res_byte  = 8'd0;
		res_kind  = KIND_END;
		if (stopped_q) begin
			has_res = q_head.last;
		end else if (q_head.cls != CLS_SEXTET) begin
			has_res   = 1'b1;
			res_kind  = (q_head.cls == CLS_PAD) ? KIND_PAD : KIND_BAD;
			stopped_d = 1'b1;
		end else begin
			pos_d = pos_q + 2'd1;
			case (pos_q)
				2'd0: begin
					pend_d = q_head.sextet;
				end
				2'd1: begin
					res_byte = {pend_q, q_head.sextet[5:4]};
					pend_d   = {2'b00, q_head.sextet[3:0]};
					has_res  = 1'b1;
					res_kind = KIND_DATA;
				end
				2'd2: begin
					res_byte = {pend_q[3:0], q_head.sextet[5:2]};
					pend_d   = {4'b0000, q_head.sextet[1:0]};
					has_res  = 1'b1;
					res_kind = KIND_DATA;
				end
				default: begin
					res_byte = {pend_q[1:0], q_head.sextet};
					pend_d   = 6'd0;
					has_res  = 1'b1;
					res_kind = KIND_DATA;
				end
			endcase
			if (q_head.last) begin
				has_res = 1'b1;
			end
		end
		// End of message clears the group position, leftover bits and stop flag
		if (q_head.last) begin
			pos_d     = 2'd0;
			pend_d    = 6'd0;
			stopped_d = 1'b0;
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 2'd0;
			pend_q    <= 6'd0;
			stopped_q <= 1'b0;
		end else if (q_pop) begin
			pos_q     <= pos_d;
			pend_q    <= pend_d;
			stopped_q <= stopped_d;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= has_res;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			byte_q <= res_byte;
			kind_q <= res_kind;
			eom_q  <= q_head.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign data_byte      = byte_q;
	assign kind           = kind_q;
	assign end_of_message = eom_q;

endmodule

FILE: rtl/base64_stream_decoder_unit.sv
// Path: a character's result passes the queue, then the result register.
// Throughput: one character and one queue entry a cycle unless the output stalls.
// The queue of QUEUE_DEPTH entries absorbs output stalls before input backpressure.
// Reset: arst_n clears group position, leftover bits, stop flag, queue and output valid.
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Base64 stream decoder: character classifier, queue and decode back end.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit
	import b64d_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] code_char
	input  logic       s_axis_tlast,   // message_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] data_byte
	output logic [1:0] m_axis_tuser,   // [1:0] kind
	output logic       m_axis_tlast    // end_of_message
);

	b64d_entry_t entry;
	b64d_entry_t head;
	logic        full;
	logic        nonempty;
	logic        pop;
	logic        push;

	assign s_axis_tready = !full;
	assign push          = s_axis_tvalid && !full;

	// Classify the incoming character
	b64d_front u_front (
		.code_char    (s_axis_tdata),
		.message_last (s_axis_tlast),
		.entry        (entry)
	);

	// Decouple front from back
	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.nonempty   (nonempty)
	);

	// Decode and present results
	b64d_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_nonempty     (nonempty),
		.q_head         (head),
		.q_pop          (pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.data_byte      (m_axis_tdata),
		.kind           (m_axis_tuser),
		.end_of_message (m_axis_tlast)
	);

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the Base64 stream decoder.
// Feeds directed and random character messages with random idle and stall
// bursts on both sides, decodes every accepted character with a local model
// and compares each output transaction with the oldest expected result.
// ----------------------------------------------------------------------------
module tb;
	import b64d_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          TEXT_ITEMS   = 1200;
	localparam int          QUIET_TAIL   = 150;   // no idling for the last items
	localparam int          WATCHDOG_MAX = 2000;  // cycles without any transaction
	localparam logic [7:0]  PAD_CHAR     = "=";

	// One input character and its end-of-message flag
	typedef struct packed {
		logic [7:0] code_char;
		logic       message_last;
	} text_char_t;

	// One decoder output
	typedef struct packed {
		logic [7:0] data_byte;
		logic [1:0] kind;
		logic       end_of_message;
	} decode_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       m_axis_tlast;

	text_char_t     text_chars[$];
	decode_result_t expected_results[$];
	int             err_count = 0;

	// Decoder model state
	logic [1:0] grp_pos;
	logic [5:0] left_bits;
	logic       halted;

	base64_stream_decoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Index 0..63 to its alphabet character
	function automatic logic [7:0] alphabet_char(input int idx);
		if (idx < 26) return 8'(8'h41 + idx);
		if (idx < 52) return 8'(8'h61 + idx - 26);
		if (idx < 62) return 8'(8'h30 + idx - 52);
		if (idx == 62) return "+";
		return "/";
	endfunction

	function automatic void reset_decode_state();
		grp_pos   = 2'd0;
		left_bits = 6'd0;
		halted    = 1'b0;
	endfunction

	// Decode one accepted character, queue the result it causes if any
	function automatic void decode_char(input logic [7:0] ch, input logic last);
		logic [5:0]     val;
		logic           in_alphabet;
		logic [7:0]     byte_out;
		logic           have_byte;
		decode_result_t res;
		byte_out    = 8'h00;
		have_byte   = 1'b0;
		in_alphabet = 1'b1;
		val         = 6'd0;
		if (ch >= "A" && ch <= "Z") val = 6'(ch - "A");
		else if (ch >= "a" && ch <= "z") val = 6'(ch - "a" + 26);
		else if (ch >= "0" && ch <= "9") val = 6'(ch - "0" + 52);
		else if (ch == "+") val = 6'd62;
		else if (ch == "/") val = 6'd63;
		else in_alphabet = 1'b0;

		// after a stop only the last character answers
		if (halted) begin
			if (last) begin
				reset_decode_state();
				res = '{8'h00, KIND_END, 1'b1};
				expected_results.push_back(res);
			end
			return;
		end

		// padding or invalid character stops the message
		if (ch == PAD_CHAR || !in_alphabet) begin
			res = '{8'h00, (ch == PAD_CHAR) ? KIND_PAD : KIND_BAD, last};
			expected_results.push_back(res);
			if (last) reset_decode_state();
			else halted = 1'b1;
			return;
		end

		// stitch leftover bits with the new sextet
		case (grp_pos)
			2'd0: begin
				left_bits = val;
			end
			2'd1: begin
				byte_out  = {left_bits, val[5:4]};
				left_bits = {2'b00, val[3:0]};
				have_byte = 1'b1;
			end
			2'd2: begin
				byte_out  = {left_bits[3:0], val[5:2]};
				left_bits = {4'b0000, val[1:0]};
				have_byte = 1'b1;
			end
			default: begin
				byte_out  = {left_bits[1:0], val};
				left_bits = 6'd0;
				have_byte = 1'b1;
			end
		endcase
		grp_pos = grp_pos + 2'd1;

		if (last) begin
			reset_decode_state();
			if (have_byte) res = '{byte_out, KIND_DATA, 1'b1};
			else res = '{8'h00, KIND_END, 1'b1};
			expected_results.push_back(res);
		end else if (have_byte) begin
			res = '{byte_out, KIND_DATA, 1'b0};
			expected_results.push_back(res);
		end
	endfunction

	function automatic void add_char(input logic [7:0] ch, input logic last);
		text_char_t item;
		item = '{ch, last};
		text_chars.push_back(item);
	endfunction

	// Whole string as one message, last flag on its final character when close_msg is set
	function automatic void add_text(input string txt, input logic close_msg);
		for (int i = 0; i < txt.len(); i++)
			add_char(txt[i], close_msg && (i == txt.len() - 1));
	endfunction

	// Stimulus: directed messages, then random messages
	initial begin
		int len;
		int pick;
		int bad_at;
		reset_decode_state();

		add_text("TWFu", 1'b1);     // full group, last on fourth character
		add_text("+/z9", 1'b1);     // alphabet extremes
		add_text("A", 1'b1);        // last with no byte
		add_text("QUJD/", 1'b1);    // last in group position 0 after a group
		add_text("TQ==", 1'b1);     // pad stop, then last ignored-state end
		add_text("QQ=", 1'b1);      // pad as last character
		add_char(8'h00, 1'b0);      // invalid stop, then ignored characters
		add_char(8'hFF, 1'b0);
		add_text("AB", 1'b1);
		add_char(8'hFF, 1'b1);      // invalid as last character
		add_text("QUJ", 1'b1);      // last in group position 2

		while (text_chars.size() < TEXT_ITEMS) begin
			pick = $urandom_range(0, 99);
			len  = $urandom_range(1, 24);
			if (pick < 70) begin
				// well-formed text, sometimes padded, sometimes left open
				for (int i = 0; i < len; i++)
					add_char(alphabet_char($urandom_range(0, 63)), 1'b0);
				case ($urandom_range(0, 3))
					0: add_char(PAD_CHAR, 1'b1);
					1: begin
						add_char(PAD_CHAR, 1'b0);
						add_char(PAD_CHAR, 1'b1);
					end
					default: text_chars[$].message_last = ($urandom_range(0, 9) != 0);
				endcase
			end else if (pick < 85) begin
				// valid text broken by one arbitrary byte
				bad_at = $urandom_range(0, len - 1);
				for (int i = 0; i < len; i++) begin
					if (i == bad_at) add_char(8'($urandom_range(0, 255)), i == len - 1);
					else add_char(alphabet_char($urandom_range(0, 63)), i == len - 1);
				end
			end else begin
				// raw noise
				for (int i = 0; i < len; i++)
					add_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end
		end
	end

	// Reset, then wait for the traffic to drain
	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk);
		while (text_chars.size() > 0 || s_axis_tvalid || expected_results.size() > 0);
		repeat (8) @(posedge clk);
		if (err_count == 0 && expected_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Input driver with idle bursts
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		text_char_t item;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'h00;
			s_axis_tlast  <= 1'b0;
			gap_left = 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) decode_char(s_axis_tdata, s_axis_tlast);
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (text_chars.size() > 0) begin
				item = text_chars.pop_front();
				s_axis_tdata  <= item.code_char;
				s_axis_tlast  <= item.message_last;
				s_axis_tvalid <= 1'b1;
				if (text_chars.size() > QUIET_TAIL && $urandom_range(0, 11) == 0)
					gap_left = $urandom_range(1, 16);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Output monitor and checker with stall bursts
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		decode_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: data_byte %0h kind %0d end_of_message %0b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					err_count++;
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tdata !== want.data_byte) begin
						$error("data_byte mismatch: expected %0h, actual %0h",
							want.data_byte, m_axis_tdata);
						err_count++;
					end
					if (m_axis_tuser !== want.kind) begin
						$error("kind mismatch: expected %0d, actual %0d",
							want.kind, m_axis_tuser);
						err_count++;
					end
					if (m_axis_tlast !== want.end_of_message) begin
						$error("end_of_message mismatch: expected %0b, actual %0b",
							want.end_of_message, m_axis_tlast);
						err_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (text_chars.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 15);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without any transaction while work is pending
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else if (text_chars.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

endmodule
